/* rtl/core/pu_pkg.sv */
// Shared constants, payload types and the factorial limit function for the permutation unranker.
package pu_pkg;

  localparam int MAX_ELEMS = 8;
  localparam int RANK_W    = 16;
  localparam int SIZE_W    = 4;
  localparam int POS_W     = 3;
  localparam int VAL_W     = 4;
  localparam int DIG_W     = $clog2(MAX_ELEMS);
  localparam int RECIP_SH  = 20;
  localparam int PROD_W    = RANK_W + RECIP_SH;

  // Word moving through the digit pipeline: remaining quotient, set size, factoradic digits.
  typedef struct packed {
    logic [RANK_W-1:0]                quo;
    logic [SIZE_W-1:0]                n;
    logic [MAX_ELEMS-1:0][DIG_W-1:0]  dig;
  } pu_item_t;

  // Word handed to the element emitter.
  typedef struct packed {
    logic [SIZE_W-1:0]                n;
    logic [MAX_ELEMS-1:0][DIG_W-1:0]  dig;
  } pu_perm_t;

  // k factorial, saturated at 2**RANK_W so that no rank reaches it.
  function automatic logic [RANK_W:0] fact_lim(input int k);
    longint f;
    f = 1;
    for (int i = 2; i <= k; i++) begin
      f = f * i;
      if (f > (longint'(1) << RANK_W)) begin
        f = longint'(1) << RANK_W;
      end
    end
    return f[RANK_W:0];
  endfunction

endpackage

/* rtl/core/pu_front.sv */
// Input stage: clamps the set size, drops empty sets and folds out-of-range ranks to zero.
module pu_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [pu_pkg::RANK_W-1:0] rank,
  input  logic [pu_pkg::SIZE_W-1:0] perm_size,
  output logic                    out_vld,
  output pu_pkg::pu_item_t        out_item,
  input  logic                    out_stall
);
  import pu_pkg::*;

  logic [RANK_W:0]   fact_tbl [MAX_ELEMS+1];
  logic [SIZE_W-1:0] n_sat;
  logic [RANK_W-1:0] rank_w;
  logic              vld;
  pu_item_t          item;

  always_comb begin
    for (int k = 0; k <= MAX_ELEMS; k++) begin
      fact_tbl[k] = fact_lim(k);
    end
  end

  always_comb begin
    n_sat  = (perm_size > SIZE_W'(MAX_ELEMS)) ? SIZE_W'(MAX_ELEMS) : perm_size;
    // a rank past the last permutation wraps to identity
    rank_w = ({1'b0, rank} >= fact_tbl[n_sat]) ? '0 : rank;
  end

  assign item_stall = vld & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!item_stall) begin
      vld <= item_valid && (perm_size != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      item.quo <= rank_w;
      item.n   <= n_sat;
      item.dig <= '0;
    end
  end

  assign out_vld  = vld;
  assign out_item = item;

endmodule

/* rtl/core/pu_digits.sv */
// Factoradic digit pipeline: one register stage per digit, each dividing by a small constant.
module pu_digits (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  pu_pkg::pu_item_t   in_item,
  output logic               in_stall,
  output logic               out_vld,
  output pu_pkg::pu_perm_t   out_perm,
  input  logic               out_stall
);
  import pu_pkg::*;

  localparam int NSTG = MAX_ELEMS - 1;

  logic     vld_r   [NSTG];
  pu_item_t item_r  [NSTG];
  logic     src_vld [NSTG];
  pu_item_t nxt     [NSTG];
  logic     stall_r [NSTG];

  for (genvar j = 0; j < NSTG; j++) begin : g_stage
    localparam int unsigned DIVISOR = j + 2;
    localparam int unsigned RECIP   = (1 << RECIP_SH) / DIVISOR;

    pu_item_t          src;
    logic [PROD_W-1:0] prod;
    logic [RANK_W-1:0] qe;
    logic [RANK_W-1:0] back;
    logic [RANK_W-1:0] rem;

    if (j == 0) begin : g_first
      assign src        = in_item;
      assign src_vld[j] = in_vld;
    end else begin : g_next
      assign src        = item_r[j-1];
      assign src_vld[j] = vld_r[j-1];
    end

    if (j == NSTG - 1) begin : g_last
      assign stall_r[j] = vld_r[j] & out_stall;
    end else begin : g_mid
      assign stall_r[j] = vld_r[j] & stall_r[j+1];
    end

    // reciprocal estimate is exact or one short; fix with one compare and subtract
    assign prod = PROD_W'(src.quo) * PROD_W'(RECIP);
    assign qe   = prod[PROD_W-1:RECIP_SH];
    assign back = qe * RANK_W'(DIVISOR);
    assign rem  = src.quo - back;

    always_comb begin
      nxt[j] = src;
      if (rem >= RANK_W'(DIVISOR)) begin
        nxt[j].quo        = qe + 1'b1;
        nxt[j].dig[j + 1] = DIG_W'(rem - RANK_W'(DIVISOR));
      end else begin
        nxt[j].quo        = qe;
        nxt[j].dig[j + 1] = DIG_W'(rem);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NSTG; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else begin
      for (int j = 0; j < NSTG; j++) begin
        if (!stall_r[j]) begin
          vld_r[j] <= src_vld[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NSTG; j++) begin
      if (!stall_r[j]) begin
        item_r[j] <= nxt[j];
      end
    end
  end

  assign in_stall     = stall_r[0];
  assign out_vld      = vld_r[NSTG-1];
  assign out_perm.n   = item_r[NSTG-1].n;
  assign out_perm.dig = item_r[NSTG-1].dig;

endmodule

/* rtl/core/pu_emit.sv */
// Element emitter: decodes one position per cycle while elem_stall allows, from the digits and a used-value mask.
module pu_emit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_vld,
  input  pu_pkg::pu_perm_t         in_perm,
  output logic                     in_stall,
  output logic                     elem_valid,
  input  logic                     elem_stall,
  output logic [pu_pkg::POS_W-1:0] position,
  output logic [pu_pkg::VAL_W-1:0] element_value,
  output logic                     last
);
  import pu_pkg::*;

  logic                            cur_vld;
  logic [SIZE_W-1:0]               cur_n;
  logic [MAX_ELEMS-1:0][DIG_W-1:0] cur_dig;
  logic [MAX_ELEMS-1:0]            used;
  logic [MAX_ELEMS-1:0]            used_next;
  logic [DIG_W-1:0]                pos;
  logic [DIG_W-1:0]                last_pos;
  logic [DIG_W-1:0]                idx;
  logic [DIG_W-1:0]                pick;
  logic [DIG_W-1:0]                seen;
  logic [DIG_W-1:0]                chosen;
  logic                            found;
  logic                            adv;
  logic                            step;
  logic                            done;

  always_comb begin
    last_pos = DIG_W'(cur_n - 1'b1);
    idx      = last_pos - pos;
    pick     = cur_dig[idx];
    // take the pick-th value not yet placed
    seen     = '0;
    chosen   = '0;
    found    = 1'b0;
    for (int j = 0; j < MAX_ELEMS; j++) begin
      if (!used[j] && !found) begin
        if (seen == pick) begin
          chosen = DIG_W'(j);
          found  = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
    used_next         = used;
    used_next[chosen] = 1'b1;
  end

  assign adv      = !elem_valid || !elem_stall;
  assign step     = cur_vld && adv;
  assign done     = step && (pos == last_pos);
  assign in_stall = cur_vld && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld    <= 1'b0;
      elem_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        cur_vld <= in_vld;
      end
      if (adv) begin
        elem_valid <= cur_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_vld) begin
      cur_n   <= in_perm.n;
      cur_dig <= in_perm.dig;
      pos     <= '0;
      used    <= '0;
    end else if (step) begin
      pos  <= pos + 1'b1;
      used <= used_next;
    end
    if (step) begin
      position      <= POS_W'(pos);
      element_value <= VAL_W'(chosen) + 1'b1;
      last          <= (pos == last_pos);
    end
  end

endmodule

/* rtl/core/permutation_unrank.sv */
// Lexicographic permutation unranker: rank and set size in, one element word per position out.
//
// Input channel: item_valid / item_stall carry rank and perm_size. A word is taken at a
// rising edge with item_valid high and item_stall low. A size of zero is taken and gives
// no output; sizes above 8 are clamped to 8. A rank at or past size factorial gives the
// identity permutation.
// Output channel: elem_valid / elem_stall carry position, element_value and last, one word
// per element in position order, with last set on the final element.
// Path: the clamp stage loads on the taking edge; the item then passes seven factoradic digit
// stages, the emitter load and the output register. Its elements follow at one per cycle
// while elem_stall does not hold the output.
// Flow: the emitter decodes one position per cycle while not stalled and holds an item of
// size n until all n positions are decoded, taking no new item before that. The clamp and
// digit stages hold up to 8 items in flight behind the emitter.
// Reset (rst, synchronous) empties every stage and the output register.
// When elem_stall is high with elem_valid set, the output word holds, the emitter and the pipeline freeze
// stage by stage, and item_stall rises once the front stage is full.
module permutation_unrank (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [pu_pkg::RANK_W-1:0] rank,
  input  logic [pu_pkg::SIZE_W-1:0] perm_size,
  output logic                      elem_valid,
  input  logic                      elem_stall,
  output logic [pu_pkg::POS_W-1:0]  position,
  output logic [pu_pkg::VAL_W-1:0]  element_value,
  output logic                      last
);
  import pu_pkg::*;

  logic     front_vld;
  logic     front_stall;
  pu_item_t front_item;
  logic     dig_vld;
  logic     dig_stall;
  pu_perm_t dig_perm;

  pu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .rank       (rank),
    .perm_size  (perm_size),
    .out_vld    (front_vld),
    .out_item   (front_item),
    .out_stall  (front_stall)
  );

  pu_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (front_vld),
    .in_item   (front_item),
    .in_stall  (front_stall),
    .out_vld   (dig_vld),
    .out_perm  (dig_perm),
    .out_stall (dig_stall)
  );

  pu_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .in_vld        (dig_vld),
    .in_perm       (dig_perm),
    .in_stall      (dig_stall),
    .elem_valid    (elem_valid),
    .elem_stall    (elem_stall),
    .position      (position),
    .element_value (element_value),
    .last          (last)
  );

endmodule
